// File: rtl/wve_pkg.sv
// Shared types, codes and constants of the wavetable voice.
`timescale 1ns / 1ps
`default_nettype none

package wve_pkg;

  // Wave table geometry
  localparam int unsigned TABLE_DEPTH = 512;
  localparam int unsigned TABLE_AW    = 9;
  localparam int unsigned SAMPLE_W    = 16;

  // Envelope point layout
  localparam int unsigned POINT_W = 40;
  localparam int unsigned LEVEL_W = 24;
  localparam int unsigned DUR_W   = 16;
  localparam int unsigned SLOPE_W = LEVEL_W + 1;

  // Divider: one quotient bit per step over the level magnitude
  localparam int unsigned DIV_STEPS = LEVEL_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 40;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE_STEP    = 3'd0,
    CFG_SWEEP_STEP   = 3'd1,
    CFG_STEP_HIGH    = 3'd2,
    CFG_STEP_LOW     = 3'd3,
    CFG_FIRST_POINT  = 3'd4,
    CFG_SECOND_POINT = 3'd5,
    CFG_THIRD_POINT  = 3'd6,
    CFG_SUSTAIN_EN   = 3'd7
  } cfg_idx_t;

  typedef enum logic [1:0] {
    KIND_TICK    = 2'd0,
    KIND_NOTE_ON = 2'd1,
    KIND_RELEASE = 2'd2,
    KIND_WRITE   = 2'd3
  } kind_t;

  // Divider request and response
  typedef struct packed {
    logic               start;
    logic [LEVEL_W-1:0] from_level;
    logic [LEVEL_W-1:0] to_level;
    logic [DUR_W-1:0]   dur;
  } div_req_t;

  typedef struct packed {
    logic                      done;
    logic signed [SLOPE_W-1:0] quotient;
  } div_rsp_t;

  function automatic logic [LEVEL_W-1:0] pt_level(input logic [POINT_W-1:0] p);
    return p[POINT_W-1:DUR_W];
  endfunction

  function automatic logic [DUR_W-1:0] pt_dur(input logic [POINT_W-1:0] p);
    return p[DUR_W-1:0];
  endfunction

endpackage

`default_nettype wire

// File: rtl/wve_div.sv
// Iterative signed slope divider: (to - from) / dur, truncating toward zero.
`timescale 1ns / 1ps
`default_nettype none

module wve_div (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire wve_pkg::div_req_t req,
  output wve_pkg::div_rsp_t      rsp
);

  logic                                 busy_r, busy_nxt;
  logic                                 done_r, done_nxt;
  logic                                 neg_r, neg_nxt;
  logic [wve_pkg::DIV_CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [wve_pkg::DUR_W-1:0]            rem_r, rem_nxt;
  logic [wve_pkg::DUR_W-1:0]            dvs_r, dvs_nxt;
  logic [wve_pkg::LEVEL_W-1:0]          quo_r, quo_nxt;

  logic signed [wve_pkg::SLOPE_W-1:0]   diff;
  logic [wve_pkg::SLOPE_W-1:0]          mag;
  logic [wve_pkg::DUR_W:0]              trial;
  logic [wve_pkg::DUR_W:0]              trial_sub;
  logic                                 ge;

  // Signed difference and its magnitude
  assign diff = $signed({1'b0, req.to_level}) - $signed({1'b0, req.from_level});
  assign mag  = diff[wve_pkg::SLOPE_W-1] ? (~diff + 1'b1) : diff;

  // One restoring step
  assign trial     = {rem_r, quo_r[wve_pkg::LEVEL_W-1]};
  assign ge        = (trial >= {1'b0, dvs_r});
  assign trial_sub = trial - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    quo_nxt  = quo_r;
    if (req.start) begin
      // load operands; a zero duration answers zero at once
      rem_nxt = '0;
      dvs_nxt = req.dur;
      cnt_nxt = '0;
      if (req.dur == '0) begin
        quo_nxt  = '0;
        neg_nxt  = 1'b0;
        done_nxt = 1'b1;
        busy_nxt = 1'b0;
      end else begin
        quo_nxt  = mag[wve_pkg::LEVEL_W-1:0];
        neg_nxt  = diff[wve_pkg::SLOPE_W-1];
        busy_nxt = 1'b1;
      end
    end else if (busy_r) begin
      // shift in one quotient bit
      rem_nxt = ge ? trial_sub[wve_pkg::DUR_W-1:0] : trial[wve_pkg::DUR_W-1:0];
      quo_nxt = {quo_r[wve_pkg::LEVEL_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == wve_pkg::DIV_CNT_W'(wve_pkg::DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r <= neg_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    quo_r <= quo_nxt;
  end

  // Apply the sign to the magnitude quotient
  always_comb begin
    rsp.done     = done_r;
    rsp.quotient = neg_r ? $signed(~{1'b0, quo_r} + 1'b1) : $signed({1'b0, quo_r});
  end

endmodule

`default_nettype wire

// File: rtl/wavetable_voice_with_envelope.sv
// Top level of the wavetable voice: sequencer, wave table, oscillator and envelope.
//
//   port group  direction  handshake          payload
//   in_*        input      in_valid/in_stall  kind, mix_in, table_index, table_value
//   out_*       output     out_valid/out_stall mix_out, voice_active
//   cfg_*       input      cfg_we             cfg_index, cfg_data
//
// A table write, release or idle tick skips S_MUL and S_ENV. A note start, and a tick
// that moves to the next envelope point, wait in S_DIV for the shared bit-serial
// slope divider (one quotient bit a cycle, none for a zero duration). Reset (rst_n low
// at a clock edge) clears the voice and configuration; the wave table holds undefined
// data until written. in_stall is high while an item is at work. A finished result
// waits in the output register, and the next item is taken meanwhile.
`timescale 1ns / 1ps
`default_nettype none

module wavetable_voice_with_envelope #(
  parameter int unsigned PHASE_SHIFT = 23
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // input channel
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [1:0]                      in_kind,
  input  wire logic signed [15:0]              in_mix_in,
  input  wire logic [8:0]                      in_table_index,
  input  wire logic signed [15:0]              in_table_value,
  // result channel
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic signed [15:0]                   out_mix_out,
  output logic                                 out_voice_active,
  // configuration port
  input  wire logic                            cfg_we,
  input  wire logic [wve_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [wve_pkg::CFG_DATA_W-1:0]  cfg_data
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_ENV  = 5'b00100,
    S_DIV  = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // configuration registers
  logic [31:0]                   base_step_r, sweep_step_r, step_high_r, step_low_r;
  logic [wve_pkg::POINT_W-1:0]   first_pt_r, second_pt_r, third_pt_r;
  logic                          sustain_en_r;

  // voice state
  logic [31:0]                        phase_r, phase_nxt;
  logic [31:0]                        step_r, step_nxt;
  logic [31:0]                        sweep_r, sweep_nxt;
  logic                               sweep_chk_r, sweep_chk_nxt;
  logic [wve_pkg::LEVEL_W-1:0]        level_r, level_nxt;
  logic [wve_pkg::DUR_W-1:0]          remain_r, remain_nxt;
  logic signed [wve_pkg::SLOPE_W-1:0] slope_r, slope_nxt;
  logic [1:0]                         pending_r, pending_nxt;
  logic                               holding_r, holding_nxt;
  logic                               armed_r, armed_nxt;
  logic                               sounding_r, sounding_nxt;

  // datapath registers
  logic signed [15:0]            res_r, res_nxt;
  logic signed [31:0]            prod_r;
  logic signed [15:0]            rdata_r;
  logic                          out_valid_r, out_valid_nxt;
  logic signed [15:0]            out_mix_r;
  logic                          out_active_r;

  // wave table
  logic [wve_pkg::SAMPLE_W-1:0]  wave_mem [wve_pkg::TABLE_DEPTH];

  logic                          in_acc;
  wve_pkg::kind_t                kind;
  logic [31:0]                   phase_shifted;
  logic [wve_pkg::TABLE_AW-1:0]  rd_idx;
  logic                          stage_go;
  logic signed [15:0]            scaled;
  wve_pkg::div_req_t             div_req;
  wve_pkg::div_rsp_t             div_rsp;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign kind     = wve_pkg::kind_t'(in_kind);

  // Table read address from the top phase bits
  assign phase_shifted = phase_r >> PHASE_SHIFT;
  assign rd_idx        = phase_shifted[wve_pkg::TABLE_AW-1:0];

  // Write and read the wave table
  always_ff @(posedge clk) begin
    if (in_acc && (kind == wve_pkg::KIND_WRITE)) begin
      wave_mem[in_table_index] <= in_table_value;
    end
    rdata_r <= wave_mem[rd_idx];
  end

  // Scale the sample by the top 16 envelope bits
  always_ff @(posedge clk) begin
    if (state_r == S_MUL) begin
      prod_r <= 32'(rdata_r * $signed({1'b0, level_r[wve_pkg::LEVEL_W-1:8]}));
    end
  end

  assign scaled   = prod_r[31:16];
  assign stage_go = !holding_r && (remain_r == '0) && (pending_r != 2'd0);

  // Divider request: note start or move to the next point
  always_comb begin
    div_req.start = (in_acc && (kind == wve_pkg::KIND_NOTE_ON)) ||
                    ((state_r == S_ENV) && stage_go);
    if (state_r == S_IDLE) begin
      div_req.from_level = '0;
      div_req.to_level   = wve_pkg::pt_level(first_pt_r);
      div_req.dur        = wve_pkg::pt_dur(first_pt_r);
    end else if (pending_r == 2'd2) begin
      div_req.from_level = wve_pkg::pt_level(first_pt_r);
      div_req.to_level   = wve_pkg::pt_level(second_pt_r);
      div_req.dur        = wve_pkg::pt_dur(second_pt_r);
    end else begin
      div_req.from_level = wve_pkg::pt_level(second_pt_r);
      div_req.to_level   = wve_pkg::pt_level(third_pt_r);
      div_req.dur        = wve_pkg::pt_dur(third_pt_r);
    end
  end

  wve_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Sequencer and voice update
  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    step_nxt      = step_r;
    sweep_nxt     = sweep_r;
    sweep_chk_nxt = sweep_chk_r;
    level_nxt     = level_r;
    remain_nxt    = remain_r;
    slope_nxt     = slope_r;
    pending_nxt   = pending_r;
    holding_nxt   = holding_r;
    armed_nxt     = armed_r;
    sounding_nxt  = sounding_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && out_stall;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          res_nxt   = in_mix_in;
          state_nxt = S_FIN;
          unique case (kind)
            wve_pkg::KIND_WRITE: begin
            end
            wve_pkg::KIND_RELEASE: begin
              armed_nxt   = 1'b0;
              holding_nxt = 1'b0;
            end
            wve_pkg::KIND_NOTE_ON: begin
              phase_nxt    = '0;
              step_nxt     = base_step_r;
              sweep_nxt    = sweep_step_r;
              level_nxt    = '0;
              remain_nxt   = wve_pkg::pt_dur(first_pt_r);
              pending_nxt  = 2'd2;
              holding_nxt  = 1'b0;
              armed_nxt    = sustain_en_r;
              sounding_nxt = 1'b1;
              state_nxt    = S_DIV;
            end
            wve_pkg::KIND_TICK: begin
              if (sounding_r) begin
                state_nxt = S_MUL;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_MUL: begin
        // advance phase and sweep the step
        phase_nxt     = phase_r + step_r;
        sweep_chk_nxt = (sweep_r != '0);
        if (sweep_r != '0) begin
          step_nxt = step_r + sweep_r;
        end
        state_nxt = S_ENV;
      end

      S_ENV: begin
        // bounce or stop the sweep at the limits
        if (sweep_chk_r) begin
          if ((step_r >= step_high_r) && (step_high_r != '0)) begin
            sweep_nxt = (step_low_r != '0) ? (32'd0 - sweep_r) : 32'd0;
          end else if (step_r <= step_low_r) begin
            sweep_nxt = (step_high_r != '0) ? (32'd0 - sweep_r) : 32'd0;
          end
        end
        res_nxt   = res_r + scaled;
        state_nxt = S_FIN;
        // advance the envelope
        priority if (holding_r) begin
        end else if (remain_r != '0) begin
          remain_nxt = remain_r - 1'b1;
          level_nxt  = level_r + slope_r[wve_pkg::LEVEL_W-1:0];
        end else if (pending_r == 2'd2) begin
          level_nxt   = wve_pkg::pt_level(first_pt_r);
          remain_nxt  = wve_pkg::pt_dur(second_pt_r);
          pending_nxt = 2'd1;
          state_nxt   = S_DIV;
        end else if (pending_r == 2'd1) begin
          level_nxt   = wve_pkg::pt_level(second_pt_r);
          remain_nxt  = wve_pkg::pt_dur(third_pt_r);
          pending_nxt = 2'd0;
          holding_nxt = armed_r;
          state_nxt   = S_DIV;
        end else begin
          sounding_nxt = 1'b0;
          res_nxt      = res_r;
        end
      end

      S_DIV: begin
        // wait for the slope
        if (div_rsp.done) begin
          slope_nxt = div_rsp.quotient;
          state_nxt = S_FIN;
        end
      end

      S_FIN: begin
        // hand the result to the output register once it is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control and voice state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= '0;
      step_r      <= '0;
      sweep_r     <= '0;
      sweep_chk_r <= 1'b0;
      level_r     <= '0;
      remain_r    <= '0;
      slope_r     <= '0;
      pending_r   <= '0;
      holding_r   <= 1'b0;
      armed_r     <= 1'b0;
      sounding_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      step_r      <= step_nxt;
      sweep_r     <= sweep_nxt;
      sweep_chk_r <= sweep_chk_nxt;
      level_r     <= level_nxt;
      remain_r    <= remain_nxt;
      slope_r     <= slope_nxt;
      pending_r   <= pending_nxt;
      holding_r   <= holding_nxt;
      armed_r     <= armed_nxt;
      sounding_r  <= sounding_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if ((state_r == S_FIN) && (!out_valid_r || !out_stall)) begin
      out_mix_r    <= res_r;
      out_active_r <= sounding_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_mix_out      = out_mix_r;
  assign out_voice_active = out_active_r;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_step_r  <= '0;
      sweep_step_r <= '0;
      step_high_r  <= '0;
      step_low_r   <= '0;
      first_pt_r   <= '0;
      second_pt_r  <= '0;
      third_pt_r   <= '0;
      sustain_en_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (wve_pkg::cfg_idx_t'(cfg_index))
        wve_pkg::CFG_BASE_STEP:    base_step_r  <= cfg_data[31:0];
        wve_pkg::CFG_SWEEP_STEP:   sweep_step_r <= cfg_data[31:0];
        wve_pkg::CFG_STEP_HIGH:    step_high_r  <= cfg_data[31:0];
        wve_pkg::CFG_STEP_LOW:     step_low_r   <= cfg_data[31:0];
        wve_pkg::CFG_FIRST_POINT:  first_pt_r   <= cfg_data;
        wve_pkg::CFG_SECOND_POINT: second_pt_r  <= cfg_data;
        wve_pkg::CFG_THIRD_POINT:  third_pt_r   <= cfg_data;
        wve_pkg::CFG_SUSTAIN_EN:   sustain_en_r <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Checks
  a_hold_sounding: assert property (@(posedge clk) disable iff (!rst_n)
    holding_r |-> sounding_r)
    else $error("envelope holds on a silent voice");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_DIV))
    else $error("slope finished outside the wait state");

  a_tick_to_mul: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (kind == wve_pkg::KIND_TICK) && sounding_r) |=> (state_r == S_MUL))
    else $error("sounding tick did not start the sample path");

  a_pending_range: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r != 2'd3)
    else $error("envelope point count out of range");

endmodule

`default_nettype wire
